/* hw/rtl/ttic_pkg.sv */
// ttic_pkg: shared types, constants and tables for the tti medium coefficient block
// used by ttic_cordic_cell, ttic_post and tti_medium_coefficients
`default_nettype none
package ttic_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int RUN_STAGES = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int STG_W = $clog2(ATAN_ENTRIES);
	localparam int XY_W = 34;
	localparam int Z_W = 28;
	localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;
	localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0] z;
		logic neg;
	} rot_t;

	// last member in the lowest bits: vs, vp, eps, dlt from the lowest bit up
	typedef struct packed {
		logic signed [14:0] dlt;
		logic signed [14:0] eps;
		logic [12:0] vp;
		logic [12:0] vs;
	} vel_t;

	function automatic logic signed [Z_W-1:0] atan_q24(input logic [STG_W-1:0] i);
		case (i)
			5'd0: atan_q24 = 28'sd13176795;
			5'd1: atan_q24 = 28'sd7778716;
			5'd2: atan_q24 = 28'sd4110060;
			5'd3: atan_q24 = 28'sd2086331;
			5'd4: atan_q24 = 28'sd1047214;
			5'd5: atan_q24 = 28'sd524117;
			5'd6: atan_q24 = 28'sd262123;
			5'd7: atan_q24 = 28'sd131069;
			default: atan_q24 = Z_W'(28'sd1 <<< (5'd24 - i));
		endcase
	endfunction

	// round q2.30 to q1.14 and clamp to plus or minus one
	function automatic logic signed [17:0] round14(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] r;
		r = (v + XY_W'(32768)) >>> 16;
		if (r > XY_W'(16384)) round14 = ONE_Q14;
		else if (r < -XY_W'(16384)) round14 = -ONE_Q14;
		else round14 = r[17:0];
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/ttic_cordic_cell.sv */
// ttic_cordic_cell: one rotation step of the cordic chain for two angles
// depends on ttic_pkg
`default_nettype none
module ttic_cordic_cell (
	input wire logic clk,
	input wire logic [ttic_pkg::STG_W-1:0] stage,
	input wire logic en,
	input wire ttic_pkg::rot_t a_in,
	input wire ttic_pkg::rot_t b_in,
	output ttic_pkg::rot_t a_q,
	output ttic_pkg::rot_t b_q
);
	function automatic ttic_pkg::rot_t step(input ttic_pkg::rot_t r,
			input logic [ttic_pkg::STG_W-1:0] i);
		ttic_pkg::rot_t o;
		o = r;
		if (r.z >= 0) begin
			o.x = r.x - (r.y >>> i);
			o.y = r.y + (r.x >>> i);
			o.z = r.z - ttic_pkg::atan_q24(i);
		end else begin
			o.x = r.x + (r.y >>> i);
			o.y = r.y - (r.x >>> i);
			o.z = r.z + ttic_pkg::atan_q24(i);
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			a_q <= step(a_in, stage);
			b_q <= step(b_in, stage);
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/ttic_post.sv */
// ttic_post: products of sines and cosines and squared velocities, three stages
// depends on ttic_pkg
`default_nettype none
module ttic_post (
	input wire logic clk,
	input wire logic [2:0] en,
	input wire logic signed [17:0] st,
	input wire logic signed [17:0] ct,
	input wire logic signed [17:0] sp,
	input wire logic signed [17:0] cp,
	input wire ttic_pkg::vel_t vel,
	output logic [207:0] res_q
);
	logic signed [17:0] sst_s1, cc_s1, ss_s1, s2p_s1, s2t_s1, ct2_s1, sp_s1, cp_s1;
	logic [25:0] vs2_s1, vp2_s1;
	logic signed [16:0] fe_s1, fd_s1;
	logic signed [15:0] xx_s2, yy_s2, zz_s2, xy_s2, yz_s2, xz_s2;
	logic [25:0] vs2_s2, vp2_s2;
	logic signed [44:0] he_s2, hd_s2;

	function automatic logic signed [17:0] m14(input logic signed [17:0] a,
			input logic signed [17:0] b);
		logic signed [35:0] p;
		p = (36'(a) * 36'(b) + 36'sd8192) >>> 14;
		return p[17:0];
	endfunction
	function automatic logic signed [17:0] d2(input logic signed [17:0] a,
			input logic signed [17:0] b);
		logic signed [35:0] p;
		p = (36'(a) * 36'(b) + 36'sd4096) >>> 13;
		return p[17:0];
	endfunction
	function automatic logic [27:0] clip(input logic signed [44:0] p);
		logic signed [44:0] r;
		r = (p + 45'sd8192) >>> 14;
		return (p <= 0) ? 28'd0 : r[27:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sst_s1 <= m14(st, st);
			cc_s1 <= m14(cp, cp);
			ss_s1 <= m14(sp, sp);
			s2p_s1 <= d2(sp, cp);
			s2t_s1 <= d2(st, ct);
			ct2_s1 <= m14(ct, ct);
			sp_s1 <= sp;
			cp_s1 <= cp;
			vs2_s1 <= vel.vs * vel.vs;
			vp2_s1 <= vel.vp * vel.vp;
			fe_s1 <= 17'sd16384 + 17'(vel.eps) * 17'sd2;
			fd_s1 <= 17'sd16384 + 17'(vel.dlt) * 17'sd2;
		end
		if (en[1]) begin
			xx_s2 <= 16'(m14(sst_s1, cc_s1));
			yy_s2 <= 16'(m14(sst_s1, ss_s1));
			zz_s2 <= ct2_s1[15:0];
			xy_s2 <= 16'(m14(sst_s1, s2p_s1));
			yz_s2 <= 16'(m14(s2t_s1, sp_s1));
			xz_s2 <= 16'(m14(s2t_s1, cp_s1));
			vs2_s2 <= vs2_s1;
			vp2_s2 <= vp2_s1;
			he_s2 <= $signed({19'd0, vp2_s1}) * 45'(fe_s1);
			hd_s2 <= $signed({19'd0, vp2_s1}) * 45'(fd_s1);
		end
		if (en[2])
			res_q <= {4'd0, clip(hd_s2), clip(he_s2), vp2_s2, vs2_s2,
				xz_s2, yz_s2, xy_s2, zz_s2, yy_s2, xx_s2};
	end
endmodule
`default_nettype wire

/* hw/rtl/tti_medium_coefficients.sv */
// tti_medium_coefficients: pipelined cordic chain plus product stages
// depends on ttic_pkg, ttic_cordic_cell, ttic_post
//
// channel  dir  handshake                 payload
// s_axis   in   s_tvalid/s_tready         angles, velocities, eps, delta
// m_axis   out  m_tvalid/m_tready         six direction and four velocity coefficients
//
// one item per cycle while the output is not stalled; the pipe is one reduction stage,
// RUN_STAGES cordic cells and three product stages
// the whole pipe advances together: a stalled output stops every stage
// reset clears only the valid bits of the stages
`default_nettype none
module tti_medium_coefficients (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// tilt[15:0] azimuth[31:16] vs[44:32] vp[57:45] eps[72:58] delta[87:73]
	input wire logic [87:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// xx yy zz xy yz xz (16 each) vs2[121:96] vp2[147:122] h2[175:148] nmo2[203:176]
	output logic [207:0] m_tdata
);
	localparam int N = ttic_pkg::RUN_STAGES;
	localparam int D = N + 4;

	logic [D-1:0] vld_q;
	logic adv;
	assign adv = m_tready || !vld_q[D-1];
	assign s_tready = adv;
	assign m_tvalid = vld_q[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[D-2:0], s_tvalid};
	end

	// angle reduction by pi
	function automatic ttic_pkg::rot_t reduce(input logic signed [15:0] ang);
		ttic_pkg::rot_t r;
		r.x = ttic_pkg::GAIN_Q30;
		r.y = '0;
		r.z = ttic_pkg::Z_W'(ang) <<< 11;
		r.neg = 1'b0;
		if (r.z > ttic_pkg::HALF_PI_Q24) begin
			r.z = r.z - ttic_pkg::PI_Q24;
			r.neg = 1'b1;
		end else if (r.z < -ttic_pkg::HALF_PI_Q24) begin
			r.z = r.z + ttic_pkg::PI_Q24;
			r.neg = 1'b1;
		end
		return r;
	endfunction

	ttic_pkg::rot_t ra [N+1];
	ttic_pkg::rot_t rb [N+1];
	ttic_pkg::vel_t vel_q [N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			ra[0] <= reduce(s_tdata[15:0]);
			rb[0] <= reduce(s_tdata[31:16]);
			vel_q[0] <= s_tdata[87:32];
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		always_ff @(posedge clk) if (adv) vel_q[g+1] <= vel_q[g];
		ttic_cordic_cell u_cell (
			.clk(clk),
			.stage(ttic_pkg::STG_W'(g)),
			.en(adv),
			.a_in(ra[g]),
			.b_in(rb[g]),
			.a_q(ra[g+1]),
			.b_q(rb[g+1])
		);
	end

	logic signed [17:0] st, ct, sp, cp;
	always_comb begin
		ct = ttic_pkg::round14(ra[N].x);
		st = ttic_pkg::round14(ra[N].y);
		cp = ttic_pkg::round14(rb[N].x);
		sp = ttic_pkg::round14(rb[N].y);
		if (ra[N].neg) begin
			ct = -ct;
			st = -st;
		end
		if (rb[N].neg) begin
			cp = -cp;
			sp = -sp;
		end
	end

	logic [207:0] res;
	ttic_post u_post (
		.clk(clk),
		.en({3{adv}}),
		.st(st), .ct(ct), .sp(sp), .cp(cp),
		.vel(vel_q[N]),
		.res_q(res)
	);
	assign m_tdata = res;
endmodule
`default_nettype wire

/* hw/rtl/ttic_checker.sv */
// ttic_checker: port level checks for tti_medium_coefficients
// bound to the top level, uses no package items
`default_nettype none
module ttic_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [207:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("not ready with empty output");
	a_zz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[47]) else $error("cos squared negative");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready) else $error("accept while stalled");
endmodule
bind tti_medium_coefficients ttic_checker u_chk (.*);
`default_nettype wire

/* test/tti_medium_coefficients_tb.sv */
// tti_medium_coefficients_tb: self-checking stream testbench for the tti coefficient block
// depends on ttic_pkg and tti_medium_coefficients
`default_nettype none
module tti_medium_coefficients_tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// tilt, azimuth, vs, vp, eps, delta from the lowest bit up
	logic [87:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// xx, yy, zz, xy, yz, xz, vs2, vp2, h2, nmo2 from the lowest bit up
	logic [207:0] m_tdata;

	localparam int LATENCY = ttic_pkg::RUN_STAGES + 4;

	typedef struct packed {
		logic [27:0] nmo2;
		logic [27:0] h2;
		logic [25:0] vp2;
		logic [25:0] vs2;
		logic [15:0] xz;
		logic [15:0] yz;
		logic [15:0] xy;
		logic [15:0] zz;
		logic [15:0] yy;
		logic [15:0] xx;
	} coef_t;

	coef_t coef_queue[$];
	int mismatches = 0;
	// idling control
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	tti_medium_coefficients i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// floor shift of a signed value
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_one(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	function automatic longint round_mul(longint a, longint b);
		return floor_shr(a * b + 8192, 14);
	endfunction

	// rotation cordic on a q3.13 angle, sine and cosine in q1.14
	function automatic void rotate_angle(input logic signed [15:0] ang, output longint s,
			output longint c);
		longint z, x, y, dx, dy;
		bit flip;
		longint atan_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		z = longint'(ang) * 2048;
		x = 652032874;
		y = 0;
		flip = 1'b0;
		// reduce by pi once when beyond a quarter turn
		if (z > 26353589) begin
			z -= 52707179;
			flip = 1'b1;
		end else if (z < -26353589) begin
			z += 52707179;
			flip = 1'b1;
		end
		for (int i = 0; i < ttic_pkg::RUN_STAGES; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		x = clamp_one(floor_shr(x + 32768, 16));
		y = clamp_one(floor_shr(y + 32768, 16));
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endfunction

	// vp^2 times (1 + 2 frac), zero when not positive
	function automatic longint scaled_vel(longint sq, longint frac);
		longint p;
		p = sq * (16384 + 2 * frac);
		if (p <= 0) return 0;
		return (p + 8192) >>> 14;
	endfunction

	function automatic coef_t predict_coefs(logic [87:0] d);
		coef_t r;
		longint st, ct, sp, cp, sst, s2t, s2p, vs, vp, vp2;
		rotate_angle(d[15:0], st, ct);
		rotate_angle(d[31:16], sp, cp);
		vs = d[44:32];
		vp = d[57:45];
		vp2 = vp * vp;
		sst = round_mul(st, st);
		s2t = floor_shr(st * ct + 4096, 13);
		s2p = floor_shr(sp * cp + 4096, 13);
		r.xx = 16'(round_mul(sst, round_mul(cp, cp)));
		r.yy = 16'(round_mul(sst, round_mul(sp, sp)));
		r.zz = 16'(round_mul(ct, ct));
		r.xy = 16'(round_mul(sst, s2p));
		r.yz = 16'(round_mul(s2t, sp));
		r.xz = 16'(round_mul(s2t, cp));
		r.vs2 = 26'(vs * vs);
		r.vp2 = 26'(vp2);
		r.h2 = 28'(scaled_vel(vp2, longint'($signed(d[72:58]))));
		r.nmo2 = 28'(scaled_vel(vp2, longint'($signed(d[87:73]))));
		return r;
	endfunction

	// send one item, with an occasional random idle burst first when source idling is on; valid stays high afterwards
	task automatic send_point(input logic signed [15:0] tilt, input logic signed [15:0] azi,
			input logic [12:0] vs, input logic [12:0] vp,
			input logic signed [14:0] eps, input logic signed [14:0] dlt);
		logic [87:0] d;
		d = {dlt, eps, vp, vs, azi, tilt};
		if (src_idle_on && $urandom_range(3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		coef_queue.push_back(predict_coefs(d));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_random_point();
		send_point(16'($urandom), 16'($urandom), 13'($urandom), 13'($urandom),
			15'($urandom), 15'($urandom));
	endtask

	// sink side: random stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_idle_on && $urandom_range(3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// result checker against the oldest prediction
	always @(posedge clk) begin
		coef_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[203:0];
			if (coef_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %h", got);
			end else begin
				want = coef_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	// directed: angle extremes, quarter and half turns
	task automatic test_angle_extremes();
		logic signed [15:0] angs[10] = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd12868,
			-16'sd12868, 16'sd12869, -16'sd12869, 16'sd25736, 16'sd1, -16'sd1};
		foreach (angs[i]) send_point(angs[i], angs[9 - i], 13'd100, 13'd200, 15'sd0, 15'sd0);
	endtask

	// directed: velocity extremes and clamp of a non-positive factor
	task automatic test_velocity_cases();
		send_point(16'sd0, 16'sd0, 13'h1FFF, 13'h1FFF, 15'sh3FFF, 15'sh3FFF);
		send_point(16'sd0, 16'sd0, 13'd0, 13'd0, 15'sh4000, 15'sh4000);
		send_point(16'sd0, 16'sd0, 13'h1FFF, 13'h1FFF, 15'sh4000, -15'sd8192);
		send_point(16'sd0, 16'sd0, 13'd5000, 13'h1FFF, -15'sd8191, -15'sd8193);
		send_point(16'sh7FFF, 16'sh8000, 13'h1FFF, 13'd1, 15'sh4000, 15'sh3FFF);
	endtask

	// pause until every result has come
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (coef_queue.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic test_random_points(input int n);
		repeat (n) send_random_point();
	endtask

	// full rate stream with no idling on either side
	task automatic test_full_rate(input int n);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		repeat (n) send_random_point();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_angle_extremes();
		test_velocity_cases();
		test_random_points(500);
		drain_results();
		test_random_points(400);
		test_full_rate(200);
		drain_results();
		if (mismatches == 0 && coef_queue.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
